[rtl/core/rlcs_pkg.sv]
// Shared types, constants and helpers for the RGB LED chain serializer.
// No dependencies; every other file in rtl/core imports this package.
package rlcs_pkg;

    localparam int LED_SLOTS = 4;
    localparam int SLOT_W    = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;
    localparam int ACT_W     = ($clog2(LED_SLOTS + 1) > 3) ? $clog2(LED_SLOTS + 1) : 3;
    localparam int CMP_W     = (ACT_W > 8) ? ACT_W : 8;

    localparam int COLOR_W   = 24;
    localparam int INDEX_W   = 8;
    localparam int TICK_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int BIT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [BIT_W-1:0]   LAST_BIT   = BIT_W'(COLOR_W - 1);
    localparam logic [COLOR_W-1:0] COLOR_ONES = {COLOR_W{1'b1}};

    localparam logic [COUNT_W-1:0] RST_LED_COUNT = COUNT_W'(1);
    localparam logic [TICK_W-1:0]  RST_ONE_HIGH  = TICK_W'(56);
    localparam logic [TICK_W-1:0]  RST_ONE_LOW   = TICK_W'(30);
    localparam logic [TICK_W-1:0]  RST_ZERO_HIGH = TICK_W'(26);
    localparam logic [TICK_W-1:0]  RST_ZERO_LOW  = TICK_W'(53);

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_START = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_COUNT = 3'd0,
        CFG_ONE_HIGH  = 3'd1,
        CFG_ONE_LOW   = 3'd2,
        CFG_ZERO_HIGH = 3'd3,
        CFG_ZERO_LOW  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0] led_count;
        logic [TICK_W-1:0]  one_high;
        logic [TICK_W-1:0]  one_low;
        logic [TICK_W-1:0]  zero_high;
        logic [TICK_W-1:0]  zero_low;
    } t_cfg;

    // Reorders a red, green, blue color into the green, red, blue wire order.
    function automatic logic [COLOR_W-1:0] grb_order(input logic [COLOR_W-1:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

endpackage

[rtl/core/rlcs_color_mem.sv]
// Color store: one write port and two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses rlcs_pkg.
module rlcs_color_mem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [rlcs_pkg::SLOT_W-1:0]   i_wr_addr,
    input  logic [rlcs_pkg::COLOR_W-1:0]  i_wr_data,
    input  logic                          i_rd_en_a,
    input  logic [rlcs_pkg::SLOT_W-1:0]   i_rd_addr_a,
    output logic [rlcs_pkg::COLOR_W-1:0]  o_rd_data_a,
    input  logic [rlcs_pkg::SLOT_W-1:0]   i_rd_addr_b,
    output logic [rlcs_pkg::COLOR_W-1:0]  o_rd_data_b
);
    import rlcs_pkg::*;

    logic [COLOR_W-1:0]   r_mem [LED_SLOTS];
    logic [LED_SLOTS-1:0] r_valid;
    logic [COLOR_W-1:0]   r_rd_a;
    logic [COLOR_W-1:0]   r_rd_b;
    logic                 r_vld_a;
    logic                 r_vld_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en_a) begin
            r_rd_a  <= r_mem[i_rd_addr_a];
            r_vld_a <= r_valid[i_rd_addr_a];
        end
        r_rd_b  <= r_mem[i_rd_addr_b];
        r_vld_b <= r_valid[i_rd_addr_b];
    end

    assign o_rd_data_a = r_vld_a ? r_rd_a : '0;
    assign o_rd_data_b = r_vld_b ? r_rd_b : '0;

endmodule

[rtl/core/rlcs_exec.sv]
// Execute stage, frame sequencer and output register of the serializer.
// Drives the color store ports and forwards a same-cycle write. Uses rlcs_pkg.
module rlcs_exec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlcs_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [rlcs_pkg::INDEX_W-1:0]  i_index,
    input  logic [rlcs_pkg::COLOR_W-1:0]  i_color,
    output logic                          o_mem_wr_en,
    output logic [rlcs_pkg::SLOT_W-1:0]   o_mem_wr_addr,
    output logic [rlcs_pkg::COLOR_W-1:0]  o_mem_wr_data,
    output logic                          o_mem_rd_en_a,
    output logic [rlcs_pkg::SLOT_W-1:0]   o_mem_rd_addr_a,
    input  logic [rlcs_pkg::COLOR_W-1:0]  i_mem_rd_data_a,
    output logic [rlcs_pkg::SLOT_W-1:0]   o_mem_rd_addr_b,
    input  logic [rlcs_pkg::COLOR_W-1:0]  i_mem_rd_data_b,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rlcs_pkg::COLOR_W-1:0]  o_read_color,
    output logic                          o_error,
    output logic                          o_pin,
    output logic                          o_busy_res,
    output logic                          o_done_res
);
    import rlcs_pkg::*;

    logic                 in_accept;
    logic                 s1_adv;
    logic [SLOT_W-1:0]    rd_addr_a;

    logic                 r_s1_valid;
    t_op                  r_s1_op;
    logic [INDEX_W-1:0]   r_s1_index;
    logic [COLOR_W-1:0]   r_s1_color;
    logic                 r_byp_hit;
    logic [COLOR_W-1:0]   r_byp_data;

    logic                 r_sending;
    logic                 r_low;
    logic [TICK_W-1:0]    r_cnt;
    logic [BIT_W-1:0]     r_bit;
    logic [SLOT_W-1:0]    r_led;
    logic [COLOR_W-1:0]   r_cur_grb;

    logic                 n_sending;
    logic                 n_low;
    logic [TICK_W-1:0]    n_cnt;
    logic [BIT_W-1:0]     n_bit;
    logic [SLOT_W-1:0]    n_led;
    logic [COLOR_W-1:0]   n_cur_grb;

    logic                 r_out_valid;
    logic [COLOR_W-1:0]   r_read_color;
    logic                 r_error;
    logic                 r_pin;
    logic                 r_busy;
    logic                 r_done;

    logic [COLOR_W-1:0]   n_read_color;
    logic                 n_error;
    logic                 n_done;
    logic                 n_wr_en;

    logic [COLOR_W-1:0]   s1_rd_color;
    logic [ACT_W-1:0]     act_count;
    logic                 idx_bad;
    logic                 cur_one;
    logic [TICK_W-1:0]    raw_len;
    logic [TICK_W-1:0]    phase_len;
    logic [SLOT_W-1:0]    next_led;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    assign rd_addr_a       = (t_op'(i_op) == OP_START) ? '0 : i_index[SLOT_W-1:0];
    assign o_mem_rd_en_a   = in_accept;
    assign o_mem_rd_addr_a = rd_addr_a;

    assign next_led        = (r_led == SLOT_W'(LED_SLOTS - 1)) ? '0 : r_led + SLOT_W'(1);
    assign o_mem_rd_addr_b = next_led;

    assign s1_rd_color = r_byp_hit ? r_byp_data : i_mem_rd_data_a;
    assign act_count   = (ACT_W'(i_cfg.led_count) > ACT_W'(LED_SLOTS)) ?
                         ACT_W'(LED_SLOTS) : ACT_W'(i_cfg.led_count);
    assign idx_bad     = CMP_W'(r_s1_index) >= CMP_W'(act_count);

    assign cur_one   = r_cur_grb[r_bit];
    assign raw_len   = r_low ? (cur_one ? i_cfg.one_low : i_cfg.zero_low)
                             : (cur_one ? i_cfg.one_high : i_cfg.zero_high);
    assign phase_len = (raw_len == '0) ? TICK_W'(1) : raw_len;

    always_comb begin
        n_sending    = r_sending;
        n_low        = r_low;
        n_cnt        = r_cnt;
        n_bit        = r_bit;
        n_led        = r_led;
        n_cur_grb    = r_cur_grb;
        n_read_color = '0;
        n_error      = 1'b0;
        n_done       = 1'b0;
        n_wr_en      = 1'b0;
        case (r_s1_op)
            OP_SET, OP_GET: begin
                if (idx_bad || (r_s1_op == OP_SET && r_sending)) begin
                    n_read_color = COLOR_ONES;
                    n_error      = 1'b1;
                end else begin
                    n_read_color = s1_rd_color;
                    n_wr_en      = (r_s1_op == OP_SET);
                end
            end
            OP_START: begin
                if (r_sending || act_count == '0) begin
                    n_error = 1'b1;
                end else begin
                    n_sending = 1'b1;
                    n_led     = '0;
                    n_bit     = LAST_BIT;
                    n_low     = 1'b0;
                    n_cnt     = '0;
                    n_cur_grb = grb_order(s1_rd_color);
                end
            end
            default: begin
                if (r_sending) begin
                    if ({1'b0, r_cnt} + 9'd1 < {1'b0, phase_len}) begin
                        n_cnt = r_cnt + TICK_W'(1);
                    end else begin
                        n_cnt = '0;
                        if (!r_low) begin
                            n_low = 1'b1;
                        end else begin
                            n_low = 1'b0;
                            if (r_bit != '0) begin
                                n_bit = r_bit - BIT_W'(1);
                            end else begin
                                n_bit = LAST_BIT;
                                if (ACT_W'(r_led) + ACT_W'(1) < act_count) begin
                                    n_led     = next_led;
                                    n_cur_grb = grb_order(i_mem_rd_data_b);
                                end else begin
                                    n_led     = '0;
                                    n_sending = 1'b0;
                                    n_done    = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
        endcase
    end

    assign o_mem_wr_en   = s1_adv && n_wr_en;
    assign o_mem_wr_addr = r_s1_index[SLOT_W-1:0];
    assign o_mem_wr_data = r_s1_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sending   <= 1'b0;
            r_low       <= 1'b0;
            r_cnt       <= '0;
            r_bit       <= LAST_BIT;
            r_led       <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_sending   <= n_sending;
                r_low       <= n_low;
                r_cnt       <= n_cnt;
                r_bit       <= n_bit;
                r_led       <= n_led;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op    <= t_op'(i_op);
            r_s1_index <= i_index;
            r_s1_color <= i_color;
            r_byp_hit  <= o_mem_wr_en && (o_mem_wr_addr == rd_addr_a);
            r_byp_data <= o_mem_wr_data;
        end
        if (s1_adv) begin
            r_cur_grb    <= n_cur_grb;
            r_read_color <= n_read_color;
            r_error      <= n_error;
            r_pin        <= n_sending && !n_low;
            r_busy       <= n_sending;
            r_done       <= n_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_color = r_read_color;
    assign o_error      = r_error;
    assign o_pin        = r_pin;
    assign o_busy_res   = r_busy;
    assign o_done_res   = r_done;

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (!r_busy && !r_pin))
        else $error("frame end reported while still busy");

    a_pin_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pin) |-> r_busy)
        else $error("pin high outside a frame");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_s1_valid) |-> s1_adv)
        else $error("item accepted over a stalled execute stage");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= LAST_BIT)
        else $error("bit position out of range");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |-> !r_sending)
        else $error("color store written during a frame");

endmodule

[rtl/core/rgb_led_chain_serializer_top.sv]
// Top level of the RGB LED chain serializer: configuration registers and wiring.
// Instantiates rlcs_color_mem and rlcs_exec; uses rlcs_pkg.
//
// Usage: items enter on the input channel (i_in_valid / o_in_ready) with an
// operation, an LED index and a color. Set and get read the color store,
// start begins a frame, and each tick item advances the serial waveform by
// one timer clock. Every item produces exactly one result on the output
// channel (o_out_valid / i_out_ready) carrying the read color, an error flag,
// the pin level, the busy flag and the end-of-frame flag.
// The color store is read at the edge that accepts an item, and the result
// is registered when the execute stage advances. One item is taken every
// cycle while the receiver takes results; the registered read of the color
// store and the execute stage set that rate. While a frame runs, the next
// LED's color is prefetched through a second read port of the store.
// A synchronous active-low reset clears the store's valid bits (all colors
// read as zero), the frame state and the configuration to its defaults.
// Configuration writes on the cfg channel are always ready and take effect
// at once. When the receiver stalls, the result holds and o_in_ready
// drops as soon as the execute stage holds an item.
module rgb_led_chain_serializer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rlcs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rlcs_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [rlcs_pkg::INDEX_W-1:0]    i_index,
    input  logic [rlcs_pkg::COLOR_W-1:0]    i_color,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rlcs_pkg::COLOR_W-1:0]    o_read_color,
    output logic                            o_error,
    output logic                            o_pin,
    output logic                            o_busy_res,
    output logic                            o_done_res
);
    import rlcs_pkg::*;

    t_cfg               r_cfg;
    logic               mem_wr_en;
    logic [SLOT_W-1:0]  mem_wr_addr;
    logic [COLOR_W-1:0] mem_wr_data;
    logic               mem_rd_en_a;
    logic [SLOT_W-1:0]  mem_rd_addr_a;
    logic [COLOR_W-1:0] mem_rd_data_a;
    logic [SLOT_W-1:0]  mem_rd_addr_b;
    logic [COLOR_W-1:0] mem_rd_data_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count <= RST_LED_COUNT;
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.one_low   <= RST_ONE_LOW;
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.zero_low  <= RST_ZERO_LOW;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LED_COUNT: r_cfg.led_count <= i_cfg_data[COUNT_W-1:0];
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_LOW:   r_cfg.one_low   <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rlcs_color_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (mem_wr_en),
        .i_wr_addr   (mem_wr_addr),
        .i_wr_data   (mem_wr_data),
        .i_rd_en_a   (mem_rd_en_a),
        .i_rd_addr_a (mem_rd_addr_a),
        .o_rd_data_a (mem_rd_data_a),
        .i_rd_addr_b (mem_rd_addr_b),
        .o_rd_data_b (mem_rd_data_b)
    );

    rlcs_exec u_exec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_index         (i_index),
        .i_color         (i_color),
        .o_mem_wr_en     (mem_wr_en),
        .o_mem_wr_addr   (mem_wr_addr),
        .o_mem_wr_data   (mem_wr_data),
        .o_mem_rd_en_a   (mem_rd_en_a),
        .o_mem_rd_addr_a (mem_rd_addr_a),
        .i_mem_rd_data_a (mem_rd_data_a),
        .o_mem_rd_addr_b (mem_rd_addr_b),
        .i_mem_rd_data_b (mem_rd_data_b),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_color    (o_read_color),
        .o_error         (o_error),
        .o_pin           (o_pin),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res)
    );

endmodule
